FILE: design/tsaf_pkg.sv
// Package for the transport stream adaptation field parser.
// Holds the item types, byte positions, flag masks and the clock value function.
// No dependencies.
package tsaf_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_start;
        logic [1:0] adaptation_control;
    } in_item_t;

    typedef struct packed {
        logic        status;
        logic [7:0]  field_length;
        logic [7:0]  flag_bits;
        logic [41:0] pcr_value;
        logic [41:0] opcr_value;
        logic [7:0]  stuffing_count;
        logic [8:0]  consumed_bytes;
    } out_item_t;

    typedef struct packed {
        logic        status;
        logic [7:0]  field_length;
        logic [7:0]  flag_bits;
        logic [47:0] pcr_group;
        logic [47:0] opcr_group;
        logic [7:0]  stuffing_count;
        logic [8:0]  consumed_bytes;
    } raw_item_t;

    localparam logic       STATUS_OK       = 1'b0;
    localparam logic       STATUS_NO_FIELD = 1'b1;

    localparam logic [1:0] CTRL_FIELD_ONLY    = 2'd2;
    localparam logic [1:0] CTRL_FIELD_PAYLOAD = 2'd3;

    localparam logic [7:0] POS_START  = 8'd0;
    localparam logic [7:0] POS_LENGTH = 8'd4;
    localparam logic [7:0] POS_FLAGS  = 8'd5;
    localparam logic [7:0] POS_PCR_END = 8'd11;
    localparam logic [7:0] POS_TWO_END = 8'd17;
    localparam logic [7:0] POS_MAX    = 8'd255;

    localparam logic [7:0] USED_NONE = 8'd1;
    localparam logic [7:0] USED_ONE  = 8'd7;
    localparam logic [7:0] USED_TWO  = 8'd13;

    localparam logic [7:0] FLAG_PCR  = 8'h10;
    localparam logic [7:0] FLAG_OPCR = 8'h08;

    localparam logic [8:0] CLOCK_MUL = 9'd300;

    function automatic logic [41:0] clock_value(input logic [47:0] group);
        logic [32:0] base;
        logic [8:0]  ext;
        logic [41:0] prod;
        base = group[47:15];
        ext  = group[8:0];
        prod = {9'b0, base} * {33'b0, CLOCK_MUL};
        return prod + {33'b0, ext};
    endfunction

endpackage

FILE: design/tsaf_clock_stage.sv
// Output stage of the adaptation field parser: forms base*300+extension.
// Converts the collected clock groups and holds the result item.
// Depends on tsaf_pkg.
module tsaf_clock_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                raw_valid,
    output logic                raw_ready,
    input  tsaf_pkg::raw_item_t raw_item,
    output logic                result_valid,
    input  logic                result_stall,
    output tsaf_pkg::out_item_t result_item
);
    import tsaf_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;
    out_item_t item_next;
    logic      load;

    assign raw_ready = !valid_reg || !result_stall;
    assign load      = raw_valid && raw_ready;

    always_comb
    begin
        item_next.status         = raw_item.status;
        item_next.field_length   = raw_item.field_length;
        item_next.flag_bits      = raw_item.flag_bits;
        item_next.pcr_value      = clock_value(raw_item.pcr_group);
        item_next.opcr_value     = clock_value(raw_item.opcr_group);
        item_next.stuffing_count = raw_item.stuffing_count;
        item_next.consumed_bytes = raw_item.consumed_bytes;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

    assign result_valid = valid_reg;
    assign result_item  = item_reg;

`ifndef SYNTH
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> result_valid)
        else $error("Accepted clock group did not reach the output.");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.status == STATUS_NO_FIELD |->
            result_item.pcr_value == '0 && result_item.opcr_value == '0)
        else $error("Error status item carries a clock value.");
`endif

endmodule

FILE: design/ts_adaptation_field_parser.sv
// Transport stream adaptation field parser. One packet byte is taken per item and one
// item can be accepted every cycle while byte_stall is low; a result is formed from the
// byte that completes it through the input register, the parse stage and the clock
// conversion register, in that order. The parse stage can hold one result while the output
// waits, so a stall on the result side reaches the byte side only once both result
// registers are full. Depends on tsaf_pkg, tsaf_clock_stage.
module ts_adaptation_field_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  tsaf_pkg::in_item_t  byte_item,
    output logic                result_valid,
    input  logic                result_stall,
    output tsaf_pkg::out_item_t result_item
);
    import tsaf_pkg::*;

    logic        s0_valid_reg;
    logic        s0_valid_next;
    in_item_t    s0_item_reg;
    logic        s0_fire;

    logic [7:0]  byte_position_reg;
    logic [7:0]  byte_position_next;
    logic [7:0]  length_reg;
    logic [7:0]  length_next;
    logic [7:0]  flags_reg;
    logic [7:0]  flags_next;
    logic [47:0] pcr_shift_reg;
    logic [47:0] pcr_shift_next;
    logic [47:0] opcr_shift_reg;
    logic [47:0] opcr_shift_next;
    logic        done_reg;
    logic        done_next;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    raw_item_t   s1_item_reg;
    raw_item_t   s1_item_next;
    logic        s1_ready;
    logic        s2_ready;

    logic [7:0]  pos;
    logic        emit;
    logic        bad_control;
    logic        has_pcr;
    logic        has_opcr;
    logic [7:0]  last_pos;
    logic [7:0]  used_bytes;

    assign s1_ready   = !s1_valid_reg || s2_ready;
    assign s0_fire    = s0_valid_reg && s1_ready;
    assign byte_stall = s0_valid_reg && !s1_ready;

    always_comb
    begin
        pos = s0_item_reg.packet_start ? POS_START : byte_position_reg;
        byte_position_next = (pos != POS_MAX) ? pos + 8'd1 : pos;
        if (pos == POS_START)
        begin
            done_next       = 1'b0;
            length_next     = '0;
            flags_next      = '0;
            pcr_shift_next  = '0;
            opcr_shift_next = '0;
        end
        else
        begin
            done_next       = done_reg;
            length_next     = length_reg;
            flags_next      = flags_reg;
            pcr_shift_next  = pcr_shift_reg;
            opcr_shift_next = opcr_shift_reg;
        end
        has_pcr  = (flags_next & FLAG_PCR) != '0;
        has_opcr = (flags_next & FLAG_OPCR) != '0;
        unique case ({has_pcr, has_opcr})
            2'b00:
            begin
                last_pos   = POS_FLAGS;
                used_bytes = USED_NONE;
            end
            2'b01, 2'b10:
            begin
                last_pos   = POS_PCR_END;
                used_bytes = USED_ONE;
            end
            2'b11:
            begin
                last_pos   = POS_TWO_END;
                used_bytes = USED_TWO;
            end
        endcase
        emit        = 1'b0;
        bad_control = 1'b0;
        if (!done_next)
        begin
            if (pos == POS_LENGTH)
            begin
                length_next = s0_item_reg.data_byte;
                if (s0_item_reg.adaptation_control != CTRL_FIELD_ONLY &&
                    s0_item_reg.adaptation_control != CTRL_FIELD_PAYLOAD)
                begin
                    emit        = 1'b1;
                    bad_control = 1'b1;
                end
                else if (s0_item_reg.data_byte == '0)
                begin
                    flags_next = '0;
                    emit       = 1'b1;
                end
            end
            else if (pos == POS_FLAGS)
            begin
                flags_next = s0_item_reg.data_byte;
                if ((s0_item_reg.data_byte & (FLAG_PCR | FLAG_OPCR)) == '0)
                begin
                    emit = 1'b1;
                end
            end
            else if (pos > POS_FLAGS && pos <= last_pos)
            begin
                if (has_pcr && pos <= POS_PCR_END)
                begin
                    pcr_shift_next = {pcr_shift_next[39:0], s0_item_reg.data_byte};
                end
                else
                begin
                    opcr_shift_next = {opcr_shift_next[39:0], s0_item_reg.data_byte};
                end
                emit = (pos == last_pos);
            end
        end
        if (emit)
        begin
            done_next = 1'b1;
        end

        if (bad_control)
        begin
            s1_item_next                = '0;
            s1_item_next.status         = STATUS_NO_FIELD;
        end
        else
        begin
            s1_item_next.status         = STATUS_OK;
            s1_item_next.field_length   = length_next;
            s1_item_next.flag_bits      = flags_next;
            s1_item_next.pcr_group      = ((flags_next & FLAG_PCR) != '0) ? pcr_shift_next : '0;
            s1_item_next.opcr_group     =
                ((flags_next & FLAG_OPCR) != '0) ? opcr_shift_next : '0;
            s1_item_next.stuffing_count =
                (length_next > used_bytes) ? length_next - used_bytes : '0;
            s1_item_next.consumed_bytes = {1'b0, length_next} + 9'd1;
        end

        if (s0_fire && emit)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s2_ready)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (byte_valid && !byte_stall)
        begin
            s0_valid_next = 1'b1;
        end
        else if (s0_fire)
        begin
            s0_valid_next = 1'b0;
        end
        else
        begin
            s0_valid_next = s0_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg      <= 1'b0;
            s1_valid_reg      <= 1'b0;
            byte_position_reg <= '0;
            length_reg        <= '0;
            flags_reg         <= '0;
            pcr_shift_reg     <= '0;
            opcr_shift_reg    <= '0;
            done_reg          <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
            s1_valid_reg <= s1_valid_next;
            if (s0_fire)
            begin
                byte_position_reg <= byte_position_next;
                length_reg        <= length_next;
                flags_reg         <= flags_next;
                pcr_shift_reg     <= pcr_shift_next;
                opcr_shift_reg    <= opcr_shift_next;
                done_reg          <= done_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            s0_item_reg <= byte_item;
        end
        if (s0_fire && emit)
        begin
            s1_item_reg <= s1_item_next;
        end
    end

    tsaf_clock_stage u_clock_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .raw_valid    (s1_valid_reg),
        .raw_ready    (s2_ready),
        .raw_item     (s1_item_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

`ifndef SYNTH
    a_emit_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
        s0_fire && emit |=> done_reg)
        else $error("Packet result given without marking the packet done.");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_ready |=> s1_valid_reg && $stable(s1_item_reg))
        else $error("Parsed item lost while the output stage was full.");

    a_position_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        s0_fire && byte_position_reg == POS_MAX && !s0_item_reg.packet_start |=>
            byte_position_reg == POS_MAX)
        else $error("Byte position wrapped past its limit.");
`endif

endmodule
